@@ hdl/fftr2_pkg.sv @@
// Shared types, constants and table functions for the 256-point radix-2 FFT core.
package fftr2_pkg;

    localparam int POINTS    = 256;
    localparam int ADDR_W    = 8;
    localparam int SAMPLE_W  = 16;
    localparam int TWID_W    = 17;
    localparam int STAGES    = 8;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RO_RD,
        ST_RO_WR,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_ADD,
        ST_BF_WA,
        ST_BF_WB,
        ST_FETCH
    } state_t;

    // Pipeline enables for the butterfly unit
    typedef struct packed {
        logic mul_en;
        logic add_en;
    } bfly_ctl_t;

    // Quarter-wave cosine, cos(pi*k/128) with 16 fraction bits, k = 0..64
    function automatic logic [TWID_W-1:0] cos_q16(input logic [6:0] k);
        logic [TWID_W-1:0] v;
        case (k)
            7'd0:  v = 17'd65536; 7'd1:  v = 17'd65516; 7'd2:  v = 17'd65457;
            7'd3:  v = 17'd65358; 7'd4:  v = 17'd65220; 7'd5:  v = 17'd65043;
            7'd6:  v = 17'd64826; 7'd7:  v = 17'd64571; 7'd8:  v = 17'd64276;
            7'd9:  v = 17'd63943; 7'd10: v = 17'd63571; 7'd11: v = 17'd63162;
            7'd12: v = 17'd62714; 7'd13: v = 17'd62228; 7'd14: v = 17'd61705;
            7'd15: v = 17'd61144; 7'd16: v = 17'd60547; 7'd17: v = 17'd59913;
            7'd18: v = 17'd59243; 7'd19: v = 17'd58538; 7'd20: v = 17'd57797;
            7'd21: v = 17'd57022; 7'd22: v = 17'd56212; 7'd23: v = 17'd55368;
            7'd24: v = 17'd54491; 7'd25: v = 17'd53581; 7'd26: v = 17'd52639;
            7'd27: v = 17'd51665; 7'd28: v = 17'd50660; 7'd29: v = 17'd49624;
            7'd30: v = 17'd48558; 7'd31: v = 17'd47464; 7'd32: v = 17'd46340;
            7'd33: v = 17'd45189; 7'd34: v = 17'd44011; 7'd35: v = 17'd42806;
            7'd36: v = 17'd41575; 7'd37: v = 17'd40319; 7'd38: v = 17'd39039;
            7'd39: v = 17'd37736; 7'd40: v = 17'd36409; 7'd41: v = 17'd35061;
            7'd42: v = 17'd33692; 7'd43: v = 17'd32302; 7'd44: v = 17'd30893;
            7'd45: v = 17'd29465; 7'd46: v = 17'd28020; 7'd47: v = 17'd26557;
            7'd48: v = 17'd25079; 7'd49: v = 17'd23586; 7'd50: v = 17'd22078;
            7'd51: v = 17'd20557; 7'd52: v = 17'd19024; 7'd53: v = 17'd17479;
            7'd54: v = 17'd15923; 7'd55: v = 17'd14359; 7'd56: v = 17'd12785;
            7'd57: v = 17'd11204; 7'd58: v = 17'd9616;  7'd59: v = 17'd8022;
            7'd60: v = 17'd6423;  7'd61: v = 17'd4821;  7'd62: v = 17'd3215;
            7'd63: v = 17'd1608;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // Reverse the bits of an 8-bit index
    function automatic logic [ADDR_W-1:0] rev8(input logic [ADDR_W-1:0] x);
        logic [ADDR_W-1:0] r;
        for (int i = 0; i < ADDR_W; i++) begin
            r[i] = x[ADDR_W-1-i];
        end
        return r;
    endfunction

endpackage

@@ hdl/fftr2_bfly.sv @@
// Shared butterfly unit: registered complex multiply, then registered sum and difference.
module fftr2_bfly #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                                 clk,
    input  fftr2_pkg::bfly_ctl_t                 ctl,
    input  logic signed [fftr2_pkg::SAMPLE_W-1:0] a_re,
    input  logic signed [fftr2_pkg::SAMPLE_W-1:0] a_im,
    input  logic signed [fftr2_pkg::SAMPLE_W-1:0] b_re,
    input  logic signed [fftr2_pkg::SAMPLE_W-1:0] b_im,
    input  logic signed [fftr2_pkg::TWID_W-1:0]   w_re,
    input  logic signed [fftr2_pkg::TWID_W-1:0]   w_im,
    output logic signed [fftr2_pkg::SAMPLE_W-1:0] sum_re,
    output logic signed [fftr2_pkg::SAMPLE_W-1:0] sum_im,
    output logic signed [fftr2_pkg::SAMPLE_W-1:0] dif_re,
    output logic signed [fftr2_pkg::SAMPLE_W-1:0] dif_im
);

    localparam int PROD_W = fftr2_pkg::SAMPLE_W + fftr2_pkg::TWID_W;

    logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
    logic signed [fftr2_pkg::SAMPLE_W-1:0] q_rr_reg, q_ii_reg, q_ri_reg, q_ir_reg;
    logic signed [fftr2_pkg::SAMPLE_W-1:0] ar_reg, ai_reg;
    logic signed [fftr2_pkg::SAMPLE_W-1:0] tr, ti;

    // Products, floored to the fraction and wrapped to 16 bits
    always_comb
    begin
        p_rr = PROD_W'(b_re) * PROD_W'(w_re);
        p_ii = PROD_W'(b_im) * PROD_W'(w_im);
        p_ri = PROD_W'(b_re) * PROD_W'(w_im);
        p_ir = PROD_W'(b_im) * PROD_W'(w_re);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            q_rr_reg <= fftr2_pkg::SAMPLE_W'(p_rr >>> FRACTION_BITS);
            q_ii_reg <= fftr2_pkg::SAMPLE_W'(p_ii >>> FRACTION_BITS);
            q_ri_reg <= fftr2_pkg::SAMPLE_W'(p_ri >>> FRACTION_BITS);
            q_ir_reg <= fftr2_pkg::SAMPLE_W'(p_ir >>> FRACTION_BITS);
            ar_reg   <= a_re;
            ai_reg   <= a_im;
        end
    end

    // Twiddled b, then sum and difference with a
    always_comb
    begin
        tr = q_rr_reg - q_ii_reg;
        ti = q_ri_reg + q_ir_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.add_en)
        begin
            sum_re <= ar_reg + tr;
            sum_im <= ai_reg + ti;
            dif_re <= ar_reg - tr;
            dif_im <= ai_reg - ti;
        end
    end

endmodule

@@ hdl/fft_radix2_256_fixed_core.sv @@
// Top level of the 256-point radix-2 decimation-in-time FFT core.
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | kind, sample_re, sample_im
// out     | output    | out_valid / out_stall| out_re, out_im, final_bin
//
// The load that completes a frame starts the transform: a bit-reversed copy into the
// work memory, then 1024 butterflies on the single butterfly unit, each writing a,
// then b, through the one write port of the work memory. A fetch registers the next
// bin, which is held on the output while out_stall is high.
// Reset clears counters and the ready flag; frame memories are not cleared.
// in_stall is high while the transform runs, a fetch is read, or a result is held.
module fft_radix2_256_fixed_core #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic signed [15:0]  sample_re,
    input  logic signed [15:0]  sample_im,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  out_re,
    output logic signed [15:0]  out_im,
    output logic                final_bin
);

    localparam int AW = fftr2_pkg::ADDR_W;
    localparam int DW = 2 * fftr2_pkg::SAMPLE_W;
    localparam int TW = fftr2_pkg::TWID_W;

    fftr2_pkg::state_t state_reg, state_next;

    logic [AW-1:0] load_cnt_reg, load_cnt_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          ready_reg, ready_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [2:0]    stage_reg, stage_next;
    logic          out_valid_reg, out_valid_next;
    logic signed [15:0] out_re_reg, out_im_reg;
    logic          final_reg;

    logic [DW-1:0] in_mem   [fftr2_pkg::POINTS];
    logic [DW-1:0] work_mem [fftr2_pkg::POINTS];
    logic [DW-1:0] in_rd_reg, rda_reg, rdb_reg;

    logic          in_xfer, out_xfer, load_xfer, fetch_xfer;
    logic [AW-1:0] half, jj, addr_a, addr_b, rd_addr_a;
    logic [6:0]    kk, qq;
    logic signed [TW-1:0] w_re, w_im, w_re_reg, w_im_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    fftr2_pkg::bfly_ctl_t bctl;
    logic signed [15:0] sum_re, sum_im, dif_re, dif_im;

    assign in_stall  = (state_reg != fftr2_pkg::ST_IDLE) || out_valid_reg;
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign load_xfer  = in_xfer && (kind == fftr2_pkg::KIND_LOAD);
    assign fetch_xfer = in_xfer && (kind == fftr2_pkg::KIND_FETCH);

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign final_bin = final_reg;

    // Butterfly addresses and twiddle index for stage s, butterfly n
    always_comb
    begin
        half   = AW'(1) << stage_reg;
        jj     = {1'b0, cnt_reg[6:0]} & (half - AW'(1));
        addr_a = (({1'b0, cnt_reg[6:0]} >> stage_reg) << (stage_reg + 3'd1)) | jj;
        addr_b = addr_a | half;
        kk     = 7'(jj << (3'd7 - stage_reg));
        qq     = 7'd0 - kk;
        if (kk <= 7'd64)
        begin
            w_re = TW'(fftr2_pkg::cos_q16(kk) >> (16 - FRACTION_BITS));
            w_im = -TW'(fftr2_pkg::cos_q16(7'd64 - kk) >> (16 - FRACTION_BITS));
        end
        else
        begin
            w_re = -TW'(fftr2_pkg::cos_q16(qq) >> (16 - FRACTION_BITS));
            w_im = -TW'(fftr2_pkg::cos_q16(7'd64 - qq) >> (16 - FRACTION_BITS));
        end
    end

    assign rd_addr_a = (state_reg == fftr2_pkg::ST_IDLE) ? rd_ptr_reg : addr_a;

    // Input frame memory: write on load, read for reorder
    always_ff @(posedge clk)
    begin
        if (load_xfer)
        begin
            in_mem[load_cnt_reg] <= {sample_im, sample_re};
        end
        in_rd_reg <= in_mem[cnt_reg];
    end

    // Work / result memory: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            work_mem[waddr] <= wdata;
        end
        rda_reg <= work_mem[rd_addr_a];
        rdb_reg <= work_mem[addr_b];
    end

    // Hold the twiddle for the multiply cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == fftr2_pkg::ST_BF_RD)
        begin
            w_re_reg <= w_re;
            w_im_reg <= w_im;
        end
    end

    fftr2_bfly #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_bfly (
        .clk    (clk),
        .ctl    (bctl),
        .a_re   (rda_reg[15:0]),
        .a_im   (rda_reg[31:16]),
        .b_re   (rdb_reg[15:0]),
        .b_im   (rdb_reg[31:16]),
        .w_re   (w_re_reg),
        .w_im   (w_im_reg),
        .sum_re (sum_re),
        .sum_im (sum_im),
        .dif_re (dif_re),
        .dif_im (dif_im)
    );

    // Next state and counters
    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        ready_next     = ready_reg;
        cnt_next       = cnt_reg;
        stage_next     = stage_reg;
        out_valid_next = out_valid_reg;
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            fftr2_pkg::ST_IDLE:
            begin
                if (load_xfer)
                begin
                    load_cnt_next = load_cnt_reg + AW'(1);
                    if (load_cnt_reg == AW'(fftr2_pkg::POINTS - 1))
                    begin
                        cnt_next   = '0;
                        state_next = fftr2_pkg::ST_RO_RD;
                    end
                end
                else if (fetch_xfer && ready_reg)
                begin
                    state_next = fftr2_pkg::ST_FETCH;
                end
            end
            fftr2_pkg::ST_RO_RD: state_next = fftr2_pkg::ST_RO_WR;
            fftr2_pkg::ST_RO_WR:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(fftr2_pkg::POINTS - 1))
                begin
                    stage_next = '0;
                    state_next = fftr2_pkg::ST_BF_RD;
                end
                else
                begin
                    state_next = fftr2_pkg::ST_RO_RD;
                end
            end
            fftr2_pkg::ST_BF_RD:  state_next = fftr2_pkg::ST_BF_MUL;
            fftr2_pkg::ST_BF_MUL: state_next = fftr2_pkg::ST_BF_ADD;
            fftr2_pkg::ST_BF_ADD: state_next = fftr2_pkg::ST_BF_WA;
            fftr2_pkg::ST_BF_WA:  state_next = fftr2_pkg::ST_BF_WB;
            fftr2_pkg::ST_BF_WB:
            begin
                cnt_next   = {1'b0, cnt_reg[6:0] + 7'd1};
                state_next = fftr2_pkg::ST_BF_RD;
                if (cnt_reg[6:0] == 7'd127)
                begin
                    stage_next = stage_reg + 3'd1;
                    if (stage_reg == 3'(fftr2_pkg::STAGES - 1))
                    begin
                        state_next  = fftr2_pkg::ST_IDLE;
                        ready_next  = 1'b1;
                        rd_ptr_next = '0;
                    end
                end
            end
            fftr2_pkg::ST_FETCH:
            begin
                out_valid_next = 1'b1;
                rd_ptr_next    = rd_ptr_reg + AW'(1);
                if (rd_ptr_reg == AW'(fftr2_pkg::POINTS - 1))
                begin
                    ready_next = 1'b0;
                end
                state_next = fftr2_pkg::ST_IDLE;
            end
            default: state_next = fftr2_pkg::ST_IDLE;
        endcase
    end

    // Memory write and butterfly controls
    always_comb
    begin
        we          = 1'b0;
        waddr       = addr_a;
        wdata       = {sum_im, sum_re};
        bctl.mul_en = 1'b0;
        bctl.add_en = 1'b0;
        case (state_reg)
            fftr2_pkg::ST_RO_WR:
            begin
                we    = 1'b1;
                waddr = fftr2_pkg::rev8(cnt_reg);
                wdata = in_rd_reg;
            end
            fftr2_pkg::ST_BF_MUL: bctl.mul_en = 1'b1;
            fftr2_pkg::ST_BF_ADD: bctl.add_en = 1'b1;
            fftr2_pkg::ST_BF_WA:  we = 1'b1;
            fftr2_pkg::ST_BF_WB:
            begin
                we    = 1'b1;
                waddr = addr_b;
                wdata = {dif_im, dif_re};
            end
            default: we = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fftr2_pkg::ST_IDLE;
            load_cnt_reg  <= '0;
            rd_ptr_reg    <= '0;
            ready_reg     <= 1'b0;
            cnt_reg       <= '0;
            stage_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            rd_ptr_reg    <= rd_ptr_next;
            ready_reg     <= ready_next;
            cnt_reg       <= cnt_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the fetched bin for transfer
    always_ff @(posedge clk)
    begin
        if (state_reg == fftr2_pkg::ST_FETCH)
        begin
            out_re_reg <= rda_reg[15:0];
            out_im_reg <= rda_reg[31:16];
            final_reg  <= (rd_ptr_reg == AW'(fftr2_pkg::POINTS - 1));
        end
    end

endmodule
